FILE: design/lgs_pkg.sv
package lgs_pkg;

  localparam int ROW_IDX_W     = 4;
  localparam int CELL_W        = 32;
  localparam int GRID_ROWS_DEF = 16;
  localparam int GRID_COLS_DEF = 32;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_STEP  = 1'b1;

  // control handed from the sequencer to each row cell
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

endpackage

FILE: design/lgs_if.sv
interface lgs_in_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [lgs_pkg::ROW_IDX_W-1:0] row_index;
  logic [lgs_pkg::CELL_W-1:0]    row_cells;

  modport source (output valid, kind, row_index, row_cells, input ready);
  modport sink   (input valid, kind, row_index, row_cells, output ready);
endinterface

interface lgs_out_if;
  logic                          valid;
  logic                          ready;
  logic [lgs_pkg::ROW_IDX_W-1:0] out_row_index;
  logic [lgs_pkg::CELL_W-1:0]    out_row_cells;
  logic                          last_row;

  modport source (output valid, out_row_index, out_row_cells, last_row, input ready);
  modport sink   (input valid, out_row_index, out_row_cells, last_row, output ready);
endinterface

FILE: design/lgs_row_cell.sv
module lgs_row_cell #(
  parameter int GRID_COLS = lgs_pkg::GRID_COLS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lgs_pkg::cell_ctl_t    ctl,
  input  logic [GRID_COLS-1:0]  shift_in,
  input  logic [GRID_COLS-1:0]  load_data,
  output logic [GRID_COLS-1:0]  row
);

  logic [GRID_COLS-1:0] row_r;
  logic [GRID_COLS-1:0] row_nxt;

  always_comb begin
    priority if (ctl.shift) begin
      row_nxt = shift_in;
    end else if (ctl.load) begin
      row_nxt = load_data;
    end else begin
      row_nxt = row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
    end else begin
      row_r <= row_nxt;
    end
  end

  assign row = row_r;

endmodule

FILE: design/lgs_row_eval.sv
module lgs_row_eval #(
  parameter int GRID_COLS = lgs_pkg::GRID_COLS_DEF
) (
  input  logic [GRID_COLS-1:0] above,
  input  logic [GRID_COLS-1:0] here,
  input  logic [GRID_COLS-1:0] below,
  output logic [GRID_COLS-1:0] next_row
);

  // pad with dead cells on both edges
  logic [GRID_COLS+1:0] a_ext;
  logic [GRID_COLS+1:0] h_ext;
  logic [GRID_COLS+1:0] b_ext;

  assign a_ext = {1'b0, above, 1'b0};
  assign h_ext = {1'b0, here,  1'b0};
  assign b_ext = {1'b0, below, 1'b0};

  always_comb begin
    logic [3:0] n;
    for (int c = 0; c < GRID_COLS; c++) begin
      n = 4'(a_ext[c]) + 4'(a_ext[c+1]) + 4'(a_ext[c+2])
        + 4'(h_ext[c])                  + 4'(h_ext[c+2])
        + 4'(b_ext[c]) + 4'(b_ext[c+1]) + 4'(b_ext[c+2]);
      next_row[c] = (n == 4'd3) || (here[c] && (n == 4'd2));
    end
  end

endmodule

FILE: design/life_generation_step.sv
// Write item: no result; the next item may follow at once.
// Step item: in_ready drops and the rows are evaluated and sent out in order from row 0;
// the row chain shifts by one cell per row, the new row entering at the tail; an
// out_ready stall holds the chain while the result register is full.
// A new item is taken the cycle after the step's last row has been registered.
// Reset (synchronous, active low) clears the grid to all dead and drops out valid.
module life_generation_step #(
  parameter int GRID_ROWS = lgs_pkg::GRID_ROWS_DEF,
  parameter int GRID_COLS = lgs_pkg::GRID_COLS_DEF
) (
  input logic      clk,
  input logic      rst_n,
  lgs_in_if.sink   in_ch,
  lgs_out_if.source out_ch
);

  localparam int RowCntW = $clog2(GRID_ROWS);

  logic                      busy_r, busy_nxt;
  logic [RowCntW-1:0]        cnt_r, cnt_nxt;
  logic [GRID_COLS-1:0]      above_r, above_nxt;
  logic                      ovalid_r, ovalid_nxt;
  logic [lgs_pkg::ROW_IDX_W-1:0] oidx_r, oidx_nxt;
  logic [lgs_pkg::CELL_W-1:0]    ocells_r, ocells_nxt;
  logic                      olast_r, olast_nxt;

  logic                      in_xfer;
  logic                      advance;
  logic                      at_last;
  logic [GRID_COLS-1:0]      below;
  logic [GRID_COLS-1:0]      fresh;
  logic [GRID_COLS-1:0]      wr_data;
  logic [GRID_COLS-1:0]      rows [GRID_ROWS];

  assign in_ch.ready = !busy_r;
  assign in_xfer     = in_ch.valid && !busy_r;
  assign advance     = busy_r && (!ovalid_r || out_ch.ready);
  assign at_last     = (cnt_r == RowCntW'(GRID_ROWS - 1));
  assign below       = at_last ? '0 : rows[1];
  assign wr_data     = GRID_COLS'(in_ch.row_cells);

  lgs_row_eval #(.GRID_COLS(GRID_COLS)) u_eval (
    .above    (above_r),
    .here     (rows[0]),
    .below    (below),
    .next_row (fresh)
  );

  for (genvar i = 0; i < GRID_ROWS; i++) begin : g_cell
    lgs_pkg::cell_ctl_t   ctl;
    logic [GRID_COLS-1:0] sin;

    assign ctl.shift = advance;
    assign ctl.load  = in_xfer && (in_ch.kind == lgs_pkg::KIND_WRITE)
                    && (int'(in_ch.row_index) == i);

    if (i == GRID_ROWS - 1) begin : g_tail
      assign sin = fresh;
    end else begin : g_mid
      assign sin = rows[i+1];
    end

    lgs_row_cell #(.GRID_COLS(GRID_COLS)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .shift_in  (sin),
      .load_data (wr_data),
      .row       (rows[i])
    );
  end

  always_comb begin
    busy_nxt   = busy_r;
    cnt_nxt    = cnt_r;
    above_nxt  = above_r;
    ovalid_nxt = ovalid_r;
    oidx_nxt   = oidx_r;
    ocells_nxt = ocells_r;
    olast_nxt  = olast_r;

    if (in_xfer && (in_ch.kind == lgs_pkg::KIND_STEP)) begin
      busy_nxt  = 1'b1;
      cnt_nxt   = '0;
      above_nxt = '0;
    end

    if (advance) begin
      ovalid_nxt = 1'b1;
      oidx_nxt   = lgs_pkg::ROW_IDX_W'(cnt_r);
      ocells_nxt = lgs_pkg::CELL_W'(fresh);
      olast_nxt  = at_last;
      above_nxt  = rows[0];
      cnt_nxt    = cnt_r + 1'b1;
      if (at_last) begin
        busy_nxt = 1'b0;
      end
    end else if (out_ch.ready) begin
      // drop the register once its row transfers
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      cnt_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      cnt_r    <= cnt_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    above_r  <= above_nxt;
    oidx_r   <= oidx_nxt;
    ocells_r <= ocells_nxt;
    olast_r  <= olast_nxt;
  end

  assign out_ch.valid         = ovalid_r;
  assign out_ch.out_row_index = oidx_r;
  assign out_ch.out_row_cells = ocells_r;
  assign out_ch.last_row      = olast_r;

endmodule

FILE: design/lgs_checker.sv
module lgs_checker #(
  parameter int GRID_ROWS = lgs_pkg::GRID_ROWS_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          in_kind,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [lgs_pkg::ROW_IDX_W-1:0] out_row_index,
  input logic [lgs_pkg::CELL_W-1:0]    out_row_cells,
  input logic                          last_row
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_row_index)
      && $stable(out_row_cells) && $stable(last_row))
    else $error("result changed while stalled");

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && last_row |-> out_row_index == lgs_pkg::ROW_IDX_W'(GRID_ROWS - 1))
    else $error("last row flag on wrong row");

  // a generation in flight blocks new items until its last row is registered
  a_busy_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !last_row |-> !in_ready)
    else $error("input taken in the middle of a generation");

  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_kind == lgs_pkg::KIND_WRITE) && !out_valid |=> !out_valid)
    else $error("row write produced a result");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind life_generation_step lgs_checker #(.GRID_ROWS(GRID_ROWS)) u_lgs_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .in_kind       (in_ch.kind),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_row_index (out_ch.out_row_index),
  .out_row_cells (out_ch.out_row_cells),
  .last_row      (out_ch.last_row)
);

FILE: verif/life_generation_step_test.sv
`timescale 1ns / 1ps

module life_generation_step_test;

  localparam int ROWS = lgs_pkg::GRID_ROWS_DEF;
  localparam int COLS = lgs_pkg::GRID_COLS_DEF;
  localparam logic [lgs_pkg::CELL_W-1:0] COL_MASK =
    {lgs_pkg::CELL_W{1'b1}} >> (lgs_pkg::CELL_W - COLS);
  localparam int ITEM_TOTAL = 380;
  localparam int QUIET_FROM = 320;

  typedef struct {
    logic [lgs_pkg::ROW_IDX_W-1:0] row_index;
    logic [lgs_pkg::CELL_W-1:0]    row_cells;
    logic                          last_row;
  } row_result_t;

  // Mirrors the grid and queues the rows each generation must produce.
  class generation_tracker;
    logic [lgs_pkg::CELL_W-1:0] grid_state [ROWS];
    row_result_t                rows_due [$];
    int                         mismatches;

    function new();
      foreach (grid_state[r]) grid_state[r] = '0;
      mismatches = 0;
    endfunction

    function int outstanding();
      return rows_due.size();
    endfunction

    function void take_item(logic kind, logic [lgs_pkg::ROW_IDX_W-1:0] idx,
                            logic [lgs_pkg::CELL_W-1:0] cells);
      logic [lgs_pkg::CELL_W-1:0] fresh [ROWS];
      logic [lgs_pkg::CELL_W-1:0] above, here, below;
      row_result_t                row;
      int                         n, cc;
      if (kind == lgs_pkg::KIND_WRITE) begin
        // rows past the grid are dropped
        if (int'(idx) < ROWS) grid_state[idx] = cells & COL_MASK;
        return;
      end
      for (int r = 0; r < ROWS; r++) begin
        above = (r > 0) ? grid_state[r-1] : '0;
        below = (r + 1 < ROWS) ? grid_state[r+1] : '0;
        here  = grid_state[r];
        fresh[r] = '0;
        for (int c = 0; c < COLS; c++) begin
          n = 0;
          for (int d = -1; d <= 1; d++) begin
            cc = c + d;
            if (cc >= 0 && cc < COLS) begin
              n += int'(above[cc]) + int'(below[cc]);
              if (d != 0) n += int'(here[cc]);
            end
          end
          if (n == 3 || (here[c] && n == 2)) fresh[r][c] = 1'b1;
        end
      end
      for (int r = 0; r < ROWS; r++) begin
        grid_state[r] = fresh[r] & COL_MASK;
        row.row_index = lgs_pkg::ROW_IDX_W'(r);
        row.row_cells = fresh[r] & COL_MASK;
        row.last_row  = (r == ROWS - 1);
        rows_due.push_back(row);
      end
    endfunction

    function void check_row(logic [lgs_pkg::ROW_IDX_W-1:0] idx,
                            logic [lgs_pkg::CELL_W-1:0] cells, logic last);
      row_result_t want;
      if (rows_due.size() == 0) begin
        $error("row %0d (cells %h) arrived with no row pending", idx, cells);
        mismatches++;
        return;
      end
      want = rows_due.pop_front();
      if (idx !== want.row_index) begin
        $error("out_row_index: expected %0d, got %0d", want.row_index, idx);
        mismatches++;
      end
      if (cells !== want.row_cells) begin
        $error("out_row_cells: expected %h, got %h", want.row_cells, cells);
        mismatches++;
      end
      if (last !== want.last_row) begin
        $error("last_row: expected %b, got %b", want.last_row, last);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic quiet;
  int   sent_items;

  generation_tracker tracker;

  lgs_in_if  in_bus ();
  lgs_out_if out_bus ();

  life_generation_step #(
    .GRID_ROWS(ROWS),
    .GRID_COLS(COLS)
  ) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_bus.sink),
    .out_ch(out_bus.source)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic [lgs_pkg::CELL_W-1:0] pick_row_cells();
    case ($urandom_range(0, 6))
      0: return $urandom();
      1: return $urandom() & $urandom();
      2: return $urandom() & $urandom() & $urandom();
      3: return $urandom() | $urandom();
      4: return 32'h7 << $urandom_range(0, lgs_pkg::CELL_W - 3);
      5: return ($urandom_range(0, 1) != 0) ? '1 : '0;
      default: return ($urandom() & $urandom()) | 32'h8000_0001;
    endcase
  endfunction

  // Present one item, with an optional idle burst first, and hold until transfer.
  task automatic send_item(logic kind, logic [lgs_pkg::ROW_IDX_W-1:0] idx,
                           logic [lgs_pkg::CELL_W-1:0] cells);
    int gap;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 6);
      @(negedge clk);
      in_bus.valid     = 1'b0;
      in_bus.kind      = 1'($urandom_range(0, 1));
      in_bus.row_index = lgs_pkg::ROW_IDX_W'($urandom());
      in_bus.row_cells = $urandom();
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_bus.valid     = 1'b1;
    in_bus.kind      = kind;
    in_bus.row_index = idx;
    in_bus.row_cells = cells;
    do @(posedge clk); while (!in_bus.ready);
    tracker.take_item(kind, idx, cells);
    sent_items++;
  endtask

  task automatic write_row(int idx, logic [lgs_pkg::CELL_W-1:0] cells);
    send_item(lgs_pkg::KIND_WRITE, lgs_pkg::ROW_IDX_W'(idx), cells);
  endtask

  task automatic step_grid();
    send_item(lgs_pkg::KIND_STEP, lgs_pkg::ROW_IDX_W'($urandom()), $urandom());
  endtask

  // Hold off the sender until every pending row has come out.
  task automatic drain_rows();
    @(negedge clk);
    in_bus.valid = 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
  endtask

  // Result side: random stall bursts, none once the quiet phase starts.
  initial begin
    int stall;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 9) == 0) begin
        stall = $urandom_range(1, 6);
        out_bus.ready = 1'b0;
        repeat (stall - 1) @(negedge clk);
      end else begin
        out_bus.ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready)
      tracker.check_row(out_bus.out_row_index, out_bus.out_row_cells, out_bus.last_row);
  end

  initial begin
    int burst;
    int steps;
    tracker = new();
    quiet = 1'b0;
    sent_items = 0;
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.kind = lgs_pkg::KIND_WRITE;
    in_bus.row_index = '0;
    in_bus.row_cells = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty grid straight out of reset
    step_grid();
    // full top and bottom rows
    write_row(0, 32'hFFFF_FFFF);
    write_row(ROWS - 1, 32'hFFFF_FFFF);
    step_grid();
    // blinkers against the left and right edges
    write_row(7, 32'h0000_0007);
    write_row(8, 32'hE000_0000);
    step_grid();
    step_grid();
    // blocks in all four corners
    write_row(0, 32'hC000_0003);
    write_row(1, 32'hC000_0003);
    write_row(ROWS - 2, 32'hC000_0003);
    write_row(ROWS - 1, 32'hC000_0003);
    write_row(7, 32'h0);
    write_row(8, 32'h0);
    step_grid();
    // checkerboard stripes
    write_row(5, 32'h5555_5555);
    write_row(6, 32'hAAAA_AAAA);
    step_grid();
    // glider
    write_row(2, 32'h0000_0002);
    write_row(3, 32'h0000_0004);
    write_row(4, 32'h0000_0007);
    step_grid();
    step_grid();

    drain_rows();

    while (sent_items < ITEM_TOTAL) begin
      if (sent_items >= QUIET_FROM) quiet = 1'b1;
      case ($urandom_range(0, 9))
        0: begin
          // whole grid reloaded
          for (int r = 0; r < ROWS; r++) write_row(r, pick_row_cells());
          step_grid();
        end
        1: step_grid();
        2: write_row($urandom_range(0, ROWS - 1), pick_row_cells());
        default: begin
          burst = $urandom_range(1, 6);
          steps = $urandom_range(1, 3);
          repeat (burst) write_row($urandom_range(0, ROWS - 1), pick_row_cells());
          repeat (steps) step_grid();
        end
      endcase
      if ($urandom_range(0, 24) == 0) drain_rows();
    end

    @(negedge clk);
    in_bus.valid = 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (3 * ROWS) @(posedge clk);
    if (tracker.mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
